[rtl/core/dat_pkg.sv]
// Types and constants shared by the device address table.
`timescale 1ns / 1ps

package dat_pkg;

   localparam int SLOT_W = 4;
   localparam logic [15:0] ETH_HEADER_BYTES = 16'd14;

   // request codes
   localparam logic [2:0] MODE_REGISTER   = 3'd0;
   localparam logic [2:0] MODE_UNREGISTER = 3'd1;
   localparam logic [2:0] MODE_LOOKUP_IP  = 3'd2;
   localparam logic [2:0] MODE_LOOKUP_MAC = 3'd3;
   localparam logic [2:0] MODE_SET_IP     = 3'd4;

   // result codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_INVALID   = 3'd1;
   localparam logic [2:0] STATUS_EXISTS    = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] device_handle;
      logic [47:0] mac_address;
      logic [31:0] ip_address;
      logic        is_ethernet;
      logic [15:0] link_mtu;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [15:0]       found_handle;
      logic [31:0]       found_ip;
      logic              ambiguous;
      logic [15:0]       payload_mtu;
      logic [SLOT_W-1:0] slot_index;
   } rsp_type;

   // one table row as stored in RAM
   typedef struct packed {
      logic [47:0] mac;
      logic [31:0] ip;
      logic [15:0] handle;
   } entry_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_COMMIT
   } state_type;

endpackage

[rtl/core/dat_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps

module dat_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/device_address_table_top.sv]
// Steps: accept in idle, read all TABLE_ENTRIES rows of the entry RAM in turn, compare
//   each row as it comes out, then commit; invalid requests skip the scan.
// Throughput: one request at a time; the sequential scan of the entry RAM (one read
//   port, one row per cycle) sets the rate.
// Reset: synchronous; clears all valid marks, the default IP and the control state.
//   Entry RAM contents are not cleared; a row counts only behind its valid mark.
`timescale 1ns / 1ps

module device_address_table_top #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dat_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dat_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);

   import dat_pkg::*;

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int EW = $bits(entry_type);
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [IW-1:0]           rd_idx_ff, rd_idx_in;
   logic                    issue_done_ff, issue_done_in;
   logic                    cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0]           cmp_idx_ff, cmp_idx_in;
   logic                    cmp_last_ff, cmp_last_in;
   logic                    hit_found_ff, hit_found_in;
   logic [IW-1:0]           hit_idx_ff, hit_idx_in;
   entry_type               hit_entry_ff, hit_entry_in;
   logic                    amb_ff, amb_in;
   logic                    free_found_ff, free_found_in;
   logic [IW-1:0]           free_idx_ff, free_idx_in;
   logic                    early_ff, early_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic [31:0]             default_ip_ff;

   logic                    ram_wr_en;
   logic [IW-1:0]           ram_wr_addr;
   entry_type               ram_wr_entry;
   logic                    ram_rd_en;
   logic [EW-1:0]           ram_rd_data;
   entry_type               rd_entry;
   logic                    key_match;
   logic                    row_match;

   dat_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_entry  = entry_type'(ram_rd_data);
   assign req_ready = (state_ff == STATE_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // key compare on the row coming out of the RAM
   always_comb begin
      key_match = 1'b0;
      unique case (req_ff.mode) inside
         MODE_REGISTER, MODE_LOOKUP_MAC: key_match = (rd_entry.mac == req_ff.mac_address);
         MODE_LOOKUP_IP:                 key_match = (rd_entry.ip == req_ff.ip_address);
         MODE_UNREGISTER, MODE_SET_IP:   key_match = (rd_entry.handle == req_ff.device_handle);
         default:                        key_match = 1'b0;
      endcase
      row_match = valid_ff[cmp_idx_ff] && key_match;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rd_idx_in     = rd_idx_ff;
      issue_done_in = issue_done_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      cmp_last_in   = cmp_last_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_entry_in  = hit_entry_ff;
      amb_in        = amb_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      early_in      = early_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = hit_idx_ff;
      ram_wr_entry  = hit_entry_ff;
      ram_rd_en     = 1'b0;

      unique case (state_ff)
         STATE_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               rd_idx_in     = '0;
               issue_done_in = 1'b0;
               hit_found_in  = 1'b0;
               amb_in        = 1'b0;
               free_found_in = 1'b0;
               early_in      = (req_data.mode > MODE_SET_IP) ||
                               ((req_data.mode == MODE_REGISTER) &&
                                ((default_ip_ff == '0) || (req_data.ip_address != '0) ||
                                 !req_data.is_ethernet));
               state_in      = early_in ? STATE_COMMIT : STATE_SCAN;
            end
         end

         STATE_SCAN: begin
            // issue one row read per cycle; compare each row in the cycle after its read
            if (!issue_done_ff) begin
               ram_rd_en    = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = rd_idx_ff;
               cmp_last_in  = (rd_idx_ff == LAST_IDX);
               rd_idx_in    = rd_idx_ff + 1'b1;
               if (rd_idx_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end
            end
            if (cmp_valid_ff) begin
               if (req_ff.mode == MODE_LOOKUP_IP) begin
                  // last match wins
                  if (row_match) begin
                     hit_found_in = 1'b1;
                     hit_idx_in   = cmp_idx_ff;
                     hit_entry_in = rd_entry;
                     amb_in       = amb_ff || hit_found_ff;
                  end
               end else if (row_match && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = cmp_idx_ff;
                  hit_entry_in = rd_entry;
               end
               if (!valid_ff[cmp_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = cmp_idx_ff;
               end
               if (cmp_last_ff) begin
                  state_in = STATE_COMMIT;
               end
            end
         end

         STATE_COMMIT: begin
            // wait for the output register; table writes happen as the result is loaded into it
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = STATE_IDLE;
               rsp_data_in  = '0;
               rsp_data_in.status = STATUS_NOT_FOUND;
               if (early_ff) begin
                  rsp_data_in.status = STATUS_INVALID;
               end else begin
                  unique case (req_ff.mode) inside
                     MODE_REGISTER: begin
                        if (hit_found_ff) begin
                           rsp_data_in.status = STATUS_EXISTS;
                        end else if (!free_found_ff) begin
                           rsp_data_in.status = STATUS_FULL;
                        end else begin
                           rsp_data_in.status      = STATUS_OK;
                           rsp_data_in.found_ip    = default_ip_ff;
                           rsp_data_in.payload_mtu =
                              (req_ff.link_mtu > ETH_HEADER_BYTES) ?
                              (req_ff.link_mtu - ETH_HEADER_BYTES) : '0;
                           rsp_data_in.slot_index  = SLOT_W'(free_idx_ff);
                           ram_wr_en           = 1'b1;
                           ram_wr_addr         = free_idx_ff;
                           ram_wr_entry.mac    = req_ff.mac_address;
                           ram_wr_entry.ip     = default_ip_ff;
                           ram_wr_entry.handle = req_ff.device_handle;
                           valid_in[free_idx_ff] = 1'b1;
                        end
                     end
                     MODE_UNREGISTER: begin
                        if (hit_found_ff) begin
                           rsp_data_in.status     = STATUS_OK;
                           rsp_data_in.found_ip   = hit_entry_ff.ip;
                           rsp_data_in.slot_index = SLOT_W'(hit_idx_ff);
                           valid_in[hit_idx_ff]   = 1'b0;
                        end
                     end
                     MODE_LOOKUP_IP, MODE_LOOKUP_MAC: begin
                        if (hit_found_ff) begin
                           rsp_data_in.status       = STATUS_OK;
                           rsp_data_in.found_handle = hit_entry_ff.handle;
                           rsp_data_in.found_ip     = hit_entry_ff.ip;
                           rsp_data_in.ambiguous    = amb_ff;
                           rsp_data_in.slot_index   = SLOT_W'(hit_idx_ff);
                        end
                     end
                     MODE_SET_IP: begin
                        if (hit_found_ff) begin
                           rsp_data_in.status     = STATUS_OK;
                           rsp_data_in.found_ip   = req_ff.ip_address;
                           rsp_data_in.slot_index = SLOT_W'(hit_idx_ff);
                           ram_wr_en       = 1'b1;
                           ram_wr_entry.ip = req_ff.ip_address;
                        end
                     end
                     default: rsp_data_in.status = STATUS_INVALID;
                  endcase
               end
            end
         end

         default: state_in = STATE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_IDLE;
         issue_done_ff <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         default_ip_ff <= '0;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         cmp_valid_ff  <= cmp_valid_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            default_ip_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      cmp_last_ff   <= cmp_last_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_entry_ff  <= hit_entry_in;
      amb_ff        <= amb_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      early_ff      <= early_in;
      rsp_data_ff   <= rsp_data_in;
   end

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (state_ff == STATE_IDLE))
      else $error("request taken outside idle");

   a_write_commit: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == STATE_COMMIT) && (!rsp_valid_ff || rsp_ready))
      else $error("table write without a result transfer slot");

   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> (state_ff == STATE_SCAN))
      else $error("compare stage busy outside scan");

   a_mtu_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status != STATUS_OK)) |-> (rsp_data_ff.payload_mtu == '0))
      else $error("payload MTU on a failed request");

   a_register_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && (req_ff.mode == MODE_REGISTER)) |=> valid_ff[$past(free_idx_ff)])
      else $error("registered slot not marked valid");

endmodule

[dv/device_address_table_top_test.sv]
// Self-checking testbench for the device address table: directed and random request streams.
`timescale 1ns / 1ps

module device_address_table_top_test;
   import dat_pkg::*;

   localparam int TABLE_ENTRIES = 16;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = TABLE_ENTRIES + 8;
   localparam logic [2:0] MODE_UNKNOWN_MIN = MODE_SET_IP + 3'd1;
   localparam logic [2:0] MODE_UNKNOWN_MAX = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   device_address_table_top #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // shadow copy of the table and the default IP register
   logic        tbl_valid [TABLE_ENTRIES];
   logic [47:0] tbl_mac [TABLE_ENTRIES];
   logic [31:0] tbl_ip [TABLE_ENTRIES];
   logic [15:0] tbl_handle [TABLE_ENTRIES];
   logic [31:0] shadow_default_ip = '0;

   req_type     pending_reqs [$];
   rsp_type     expected_rsps [$];
   rsp_type     exp_rsp;
   logic        req_taken = 1'b0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          req_count = 0;
   int          rsp_ok_count = 0;
   int          rsp_full_count = 0;
   int          rsp_miss_count = 0;

   logic [47:0] mac_pool [24];
   logic [15:0] handle_pool [12];
   logic [31:0] ip_pool [6];

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic rsp_type predict_table_rsp(req_type rq);
      rsp_type r;
      int      hit;
      int      match_count;
      r = '0;
      r.status = STATUS_NOT_FOUND;
      hit = -1;
      match_count = 0;
      case (rq.mode)
         MODE_REGISTER: begin
            if (shadow_default_ip == '0 || rq.ip_address != '0 || !rq.is_ethernet) begin
               r.status = STATUS_INVALID;
            end else begin
               for (int i = 0; i < TABLE_ENTRIES; i++)
                  if (tbl_valid[i] && tbl_mac[i] == rq.mac_address) hit = i;
               if (hit >= 0) begin
                  r.status = STATUS_EXISTS;
               end else begin
                  for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
                     if (!tbl_valid[i]) hit = i;
                  if (hit < 0) begin
                     r.status = STATUS_FULL;
                  end else begin
                     tbl_valid[hit] = 1'b1;
                     tbl_mac[hit] = rq.mac_address;
                     tbl_ip[hit] = shadow_default_ip;
                     tbl_handle[hit] = rq.device_handle;
                     r.status = STATUS_OK;
                     r.found_ip = shadow_default_ip;
                     r.payload_mtu = (rq.link_mtu > ETH_HEADER_BYTES) ?
                                     rq.link_mtu - ETH_HEADER_BYTES : 16'd0;
                     r.slot_index = hit[SLOT_W-1:0];
                  end
               end
            end
         end
         MODE_UNREGISTER, MODE_SET_IP: begin
            // lowest valid slot with this handle
            for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
               if (tbl_valid[i] && tbl_handle[i] == rq.device_handle) hit = i;
            if (hit >= 0) begin
               r.status = STATUS_OK;
               r.slot_index = hit[SLOT_W-1:0];
               if (rq.mode == MODE_UNREGISTER) begin
                  tbl_valid[hit] = 1'b0;
                  r.found_ip = tbl_ip[hit];
               end else begin
                  tbl_ip[hit] = rq.ip_address;
                  r.found_ip = rq.ip_address;
               end
            end
         end
         MODE_LOOKUP_IP: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (tbl_valid[i] && tbl_ip[i] == rq.ip_address) begin
                  match_count++;
                  hit = i;
               end
            end
            if (hit >= 0) begin
               r.status = STATUS_OK;
               r.found_handle = tbl_handle[hit];
               r.found_ip = tbl_ip[hit];
               r.ambiguous = (match_count > 1);
               r.slot_index = hit[SLOT_W-1:0];
            end
         end
         MODE_LOOKUP_MAC: begin
            for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
               if (tbl_valid[i] && tbl_mac[i] == rq.mac_address) hit = i;
            if (hit >= 0) begin
               r.status = STATUS_OK;
               r.found_handle = tbl_handle[hit];
               r.found_ip = tbl_ip[hit];
               r.slot_index = hit[SLOT_W-1:0];
            end
         end
         default: r.status = STATUS_INVALID;
      endcase
      return r;
   endfunction

   task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
         error_count++;
      end
   endtask

   // driver: new payload only after the previous transfer completed
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(predict_table_rsp(req_data));
            req_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0h", $time, rsp_data);
               error_count++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               check_field("status", 48'(exp_rsp.status), 48'(rsp_data.status));
               check_field("found_handle", 48'(exp_rsp.found_handle),
                           48'(rsp_data.found_handle));
               check_field("found_ip", 48'(exp_rsp.found_ip), 48'(rsp_data.found_ip));
               check_field("ambiguous", 48'(exp_rsp.ambiguous), 48'(rsp_data.ambiguous));
               check_field("payload_mtu", 48'(exp_rsp.payload_mtu),
                           48'(rsp_data.payload_mtu));
               check_field("slot_index", 48'(exp_rsp.slot_index), 48'(rsp_data.slot_index));
               if (exp_rsp.status == STATUS_OK) rsp_ok_count++;
               if (exp_rsp.status == STATUS_FULL) rsp_full_count++;
               if (exp_rsp.status == STATUS_NOT_FOUND) rsp_miss_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, expected_rsps.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic push_req(logic [2:0] mode, logic [15:0] handle, logic [47:0] mac,
                           logic [31:0] ip, logic eth, logic [15:0] mtu);
      req_type rq;
      rq.mode = mode;
      rq.device_handle = handle;
      rq.mac_address = mac;
      rq.ip_address = ip;
      rq.is_ethernet = eth;
      rq.link_mtu = mtu;
      pending_reqs.push_back(rq);
   endtask

   task automatic write_default_ip(logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      shadow_default_ip = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic add_random_reqs(int count);
      req_type rq;
      int      pick;
      for (int n = 0; n < count; n++) begin
         rq.device_handle = 16'($urandom);
         rq.mac_address = 48'({$urandom, $urandom});
         rq.ip_address = $urandom;
         rq.is_ethernet = 1'($urandom);
         rq.link_mtu = ($urandom_range(99) < 20) ? 16'($urandom_range(20)) : 16'($urandom);
         if ($urandom_range(99) < 85) rq.device_handle = handle_pool[$urandom_range(11)];
         if ($urandom_range(99) < 85) rq.mac_address = mac_pool[$urandom_range(23)];
         pick = $urandom_range(99);
         if (pick < 30) begin
            rq.mode = MODE_REGISTER;
            // mostly well-formed so the table fills and churns
            if ($urandom_range(99) < 85) begin
               rq.ip_address = '0;
               rq.is_ethernet = 1'b1;
            end
         end else if (pick < 50) begin
            rq.mode = MODE_UNREGISTER;
         end else if (pick < 65) begin
            rq.mode = MODE_LOOKUP_IP;
            pick = $urandom_range(99);
            if (pick < 60) rq.ip_address = ip_pool[$urandom_range(5)];
            else if (pick < 85) rq.ip_address = shadow_default_ip;
         end else if (pick < 80) begin
            rq.mode = MODE_LOOKUP_MAC;
         end else if (pick < 95) begin
            rq.mode = MODE_SET_IP;
            if ($urandom_range(99) < 70) rq.ip_address = ip_pool[$urandom_range(5)];
         end else begin
            rq.mode = 3'($urandom_range(MODE_UNKNOWN_MAX, MODE_UNKNOWN_MIN));
         end
         pending_reqs.push_back(rq);
      end
   endtask

   initial begin
      for (int i = 0; i < 24; i++) mac_pool[i] = 48'({$urandom, $urandom});
      for (int i = 0; i < 12; i++) handle_pool[i] = 16'($urandom);
      for (int i = 0; i < 6; i++) ip_pool[i] = $urandom;
      mac_pool[0] = '0;
      mac_pool[1] = '1;
      handle_pool[0] = '0;
      handle_pool[1] = '1;
      ip_pool[0] = '0;
      ip_pool[1] = '1;
      for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;

      send_idle_pct = 10;
      recv_idle_pct = 81;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // default IP still zero after reset: register is refused
      push_req(MODE_REGISTER, 16'h0001, 48'h0000_0000_0100, '0, 1'b1, 16'd1500);
      wait_drained();

      write_default_ip('1);
      push_req(MODE_REGISTER, 16'h0002, 48'h0000_0000_0200, '0, 1'b0, 16'd1500);
      push_req(MODE_REGISTER, 16'h0002, 48'h0000_0000_0200, 32'h1, 1'b1, 16'd1500);
      // fill every slot; small MTUs and a repeated handle among them
      push_req(MODE_REGISTER, 16'h0000, '0, '0, 1'b1, 16'd0);
      push_req(MODE_REGISTER, '1, '1, '0, 1'b1, '1);
      push_req(MODE_REGISTER, 16'h0007, 48'h0000_0000_0013, '0, 1'b1, 16'd13);
      push_req(MODE_REGISTER, 16'h0007, 48'h0000_0000_0014, '0, 1'b1, 16'd14);
      push_req(MODE_REGISTER, 16'h0008, 48'h0000_0000_0015, '0, 1'b1, 16'd15);
      for (int i = 5; i < TABLE_ENTRIES; i++)
         push_req(MODE_REGISTER, 16'(16'h0100 + i), 48'h1000 + i, '0, 1'b1, 16'($urandom));
      push_req(MODE_REGISTER, 16'h0009, 48'h2000, '0, 1'b1, 16'd1500);
      push_req(MODE_REGISTER, 16'h0009, '0, '0, 1'b1, 16'd1500);
      push_req(MODE_LOOKUP_IP, '0, '0, '1, 1'b0, '0);
      push_req(MODE_SET_IP, 16'h0007, '0, 32'hC0A8_0001, 1'b0, '0);
      push_req(MODE_LOOKUP_IP, '0, '0, 32'hC0A8_0001, 1'b0, '0);
      push_req(MODE_LOOKUP_MAC, '0, '1, '0, 1'b0, '0);
      push_req(MODE_UNREGISTER, 16'h0007, '0, '0, 1'b0, '0);
      push_req(MODE_UNREGISTER, 16'h0007, '0, '0, 1'b0, '0);
      push_req(MODE_UNREGISTER, 16'h0007, '0, '0, 1'b0, '0);
      push_req(MODE_SET_IP, 16'h0007, '0, 32'h1, 1'b0, '0);
      push_req(MODE_LOOKUP_MAC, '0, 48'h2000, '0, 1'b0, '0);
      push_req(MODE_LOOKUP_IP, '0, '0, 32'h1234, 1'b0, '0);
      push_req(MODE_UNKNOWN_MIN, '1, '1, '1, 1'b1, '1);
      push_req(MODE_UNKNOWN_MAX, '0, '0, '0, 1'b0, '0);
      push_req(MODE_REGISTER, 16'h0009, 48'h2000, '0, 1'b1, 16'd1500);
      wait_drained();

      write_default_ip(32'h1);
      add_random_reqs(460);
      wait_drained();

      send_idle_pct = 81;
      recv_idle_pct = 10;
      write_default_ip($urandom);
      add_random_reqs(460);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_default_ip('0);
      add_random_reqs(50);
      wait_drained();

      write_default_ip('1);
      add_random_reqs(460);
      wait_drained();

      $display("Ran %0d table requests over five default-IP settings and three idle profiles.",
               req_count);
      $display("Responses: %0d ok, %0d table full, %0d not found, %0d errors.",
               rsp_ok_count, rsp_full_count, rsp_miss_count, error_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
